// ===== rtl/core/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types and constants of the slotted MAC sink acknowledgment collector.
// ----------------------------------------------------------------------------
package smac_pkg;

    // input command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_RX_START = 3'd3;
    localparam logic [2:0] CMD_RX_END   = 3'd4;
    localparam logic [2:0] CMD_TX_END   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_OWN_ADDR    = 3'd0;
    localparam logic [2:0] REG_RX_WINDOW   = 3'd1;
    localparam logic [2:0] REG_TX_PERIOD   = 3'd2;
    localparam logic [2:0] REG_START_DELAY = 3'd3;
    localparam logic [2:0] REG_ENTRY_BYTES = 3'd4;
    localparam logic [2:0] REG_NODE_COUNT  = 3'd5;

    // configuration reset values
    localparam logic [7:0]  RST_OWN_ADDR    = 8'd0;
    localparam logic [31:0] RST_RX_WINDOW   = 32'd1000;
    localparam logic [31:0] RST_TX_PERIOD   = 32'd100;
    localparam logic [31:0] RST_START_DELAY = 32'd0;
    localparam logic [7:0]  RST_ENTRY_BYTES = 8'd1;
    localparam logic [5:0]  RST_NODE_COUNT  = 6'd16;

    // result kinds
    typedef enum logic [3:0] {
        KIND_RX_ACCEPTED = 4'd0,
        KIND_RX_BUSY     = 4'd1,
        KIND_DELIVERED   = 4'd2,
        KIND_CORRUPT     = 4'd3,
        KIND_NOT_MINE    = 4'd4,
        KIND_ACK_DROPPED = 4'd5,
        KIND_OUTSIDE     = 4'd6,
        KIND_ACK_HEADER  = 4'd7,
        KIND_ACK_ENTRY   = 4'd8
    } t_kind;

    // operations passed from front to back
    typedef enum logic [2:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_RX_START,
        OP_RX_END,
        OP_TX_END
    } t_op;

    // receive-end classification made in the front
    typedef enum logic [1:0] {
        RXC_CORRUPT,
        RXC_NOT_MINE,
        RXC_ACK,
        RXC_DATA
    } t_rxc;

    typedef enum logic [1:0] {
        RADIO_IDLE = 2'd0,
        RADIO_RX   = 2'd1,
        RADIO_TX   = 2'd2
    } t_radio;

    typedef enum logic {
        BS_IDLE,
        BS_ENTRY
    } t_bstate;

    typedef struct packed {
        logic [2:0] cmd;
        logic       rx_error;
        logic [7:0] dest_addr;
        logic [7:0] src_addr;
        logic       is_ack_frame;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  entry_addr;
        logic [5:0]  ack_count;
        logic [13:0] ack_bytes;
        logic        list_overflow;
        logic        last;
        logic [31:0] delivered_total;
        logic [31:0] error_total;
        logic [31:0] sent_total;
    } t_result;

    typedef struct packed {
        t_op        op;
        t_rxc       rxc;
        logic [7:0] src_addr;
    } t_job;

    typedef struct packed {
        logic [7:0]  own_addr;
        logic [31:0] rx_window;
        logic [31:0] tx_period;
        logic [31:0] start_delay;
        logic [7:0]  entry_bytes;
        logic [5:0]  node_count;
    } t_cfg;

endpackage

// ===== rtl/core/smac_queue.sv =====
// ----------------------------------------------------------------------------
// smac_queue
// Two-entry first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module smac_queue #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    T           r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/smac_front.sv =====
// ----------------------------------------------------------------------------
// smac_front
// Takes input requests, decodes the command and classifies received frames.
// ----------------------------------------------------------------------------
module smac_front (
    input  smac_pkg::t_item i_item,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_own_addr,
    input  logic            i_q_full,
    output logic            o_q_push,
    output smac_pkg::t_job  o_job
);
    import smac_pkg::*;

    logic w_known;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full && w_known;

    always_comb begin
        // command decode, unused codes are taken and dropped
        w_known = 1'b1;
        o_job.op = OP_TICK;
        unique case (i_item.cmd)
            CMD_TICK:     o_job.op = OP_TICK;
            CMD_START:    o_job.op = OP_START;
            CMD_STOP:     o_job.op = OP_STOP;
            CMD_RX_START: o_job.op = OP_RX_START;
            CMD_RX_END:   o_job.op = OP_RX_END;
            CMD_TX_END:   o_job.op = OP_TX_END;
            default:      w_known = 1'b0;
        endcase

        // frame checks in priority order, window check is left to the back
        priority if (i_item.rx_error) begin
            o_job.rxc = RXC_CORRUPT;
        end else if (i_item.dest_addr != i_own_addr) begin
            o_job.rxc = RXC_NOT_MINE;
        end else if (i_item.is_ack_frame) begin
            o_job.rxc = RXC_ACK;
        end else begin
            o_job.rxc = RXC_DATA;
        end
        o_job.src_addr = i_item.src_addr;
    end

endmodule

// ===== rtl/core/smac_back.sv =====
// ----------------------------------------------------------------------------
// smac_back
// Holds the MAC state, runs the window countdown, keeps the success list
// and walks it one entry per cycle, unless results stall, when an ack goes out.
// ----------------------------------------------------------------------------
module smac_back #(
    parameter int MAX_NODES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smac_pkg::t_cfg    i_cfg,
    input  logic              i_job_valid,
    input  smac_pkg::t_job    i_job,
    output logic              o_job_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output smac_pkg::t_result o_res
);
    import smac_pkg::*;

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    t_bstate     r_state, n_state;
    logic        r_running, n_running;
    logic        r_in_rx, n_in_rx;
    t_radio      r_radio, n_radio;
    logic [31:0] r_countdown, n_countdown;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic        r_ovf, n_ovf;
    logic [31:0] r_deliv, n_deliv;
    logic [31:0] r_err, n_err;
    logic [31:0] r_sent, n_sent;
    logic [7:0]  r_mem [MAX_NODES];
    logic [7:0]  r_rd_data;
    logic        w_take;
    logic        w_ack_start;
    logic        w_wr_en;
    logic        w_entry_last;
    logic [13:0] w_ack_bytes;

    assign w_take       = (r_state == BS_IDLE) && i_job_valid && !i_res_full;
    assign o_job_pop    = w_take;
    assign w_entry_last = ((r_idx + CNT_W'(1)) == r_count);
    assign w_ack_bytes  = {6'd0, i_cfg.entry_bytes} * {8'd0, i_cfg.node_count};

    // next state of the list walk
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (w_ack_start && (r_count != '0)) begin
                    n_state = BS_ENTRY;
                end
            end
            BS_ENTRY: begin
                if (!i_res_full && w_entry_last) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // job execution and result generation
    always_comb begin
        n_running   = r_running;
        n_in_rx     = r_in_rx;
        n_radio     = r_radio;
        n_countdown = r_countdown;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_deliv     = r_deliv;
        n_err       = r_err;
        n_sent      = r_sent;
        n_idx       = '0;
        w_ack_start = 1'b0;
        w_wr_en     = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;

        unique case (r_state)
            BS_IDLE: begin
                if (w_take) begin
                    unique case (i_job.op)
                        OP_TICK: begin
                            if (r_running) begin
                                if (r_countdown <= 32'd1) begin
                                    if (r_in_rx) begin
                                        // receive window closes: header first
                                        n_in_rx         = 1'b0;
                                        n_radio         = RADIO_TX;
                                        n_countdown     = i_cfg.tx_period;
                                        w_ack_start     = 1'b1;
                                        o_res_push      = 1'b1;
                                        o_res.kind      = KIND_ACK_HEADER;
                                        o_res.ack_count = 6'(r_count);
                                        o_res.ack_bytes = w_ack_bytes;
                                        o_res.last      = (r_count == '0);
                                    end else begin
                                        // receive window opens with an empty list
                                        n_count     = '0;
                                        n_ovf       = 1'b0;
                                        n_in_rx     = 1'b1;
                                        n_countdown = i_cfg.rx_window;
                                    end
                                end else begin
                                    n_countdown = r_countdown - 32'd1;
                                end
                            end
                        end
                        OP_START: begin
                            n_running   = 1'b1;
                            n_countdown = i_cfg.start_delay;
                        end
                        OP_STOP: begin
                            n_running = 1'b0;
                            n_count   = '0;
                            n_ovf     = 1'b0;
                        end
                        OP_RX_START: begin
                            o_res_push = 1'b1;
                            if (r_radio == RADIO_IDLE) begin
                                n_radio    = RADIO_RX;
                                o_res.kind = KIND_RX_ACCEPTED;
                            end else begin
                                o_res.kind = KIND_RX_BUSY;
                            end
                        end
                        OP_RX_END: begin
                            o_res_push = 1'b1;
                            n_radio    = RADIO_IDLE;
                            unique case (i_job.rxc)
                                RXC_CORRUPT: begin
                                    n_err      = r_err + 32'd1;
                                    o_res.kind = KIND_CORRUPT;
                                end
                                RXC_NOT_MINE: o_res.kind = KIND_NOT_MINE;
                                RXC_ACK:      o_res.kind = KIND_ACK_DROPPED;
                                RXC_DATA: begin
                                    if (!r_in_rx) begin
                                        o_res.kind = KIND_OUTSIDE;
                                    end else begin
                                        n_deliv    = r_deliv + 32'd1;
                                        o_res.kind = KIND_DELIVERED;
                                        if (r_count < CNT_W'(MAX_NODES)) begin
                                            w_wr_en = 1'b1;
                                            n_count = r_count + CNT_W'(1);
                                        end else begin
                                            n_ovf = 1'b1;
                                        end
                                    end
                                end
                                default: o_res.kind = KIND_CORRUPT;
                            endcase
                        end
                        OP_TX_END: begin
                            n_sent  = r_sent + 32'd1;
                            n_radio = RADIO_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            BS_ENTRY: begin
                // one entry per cycle unless results stall; read data belongs to r_idx
                o_res.kind       = KIND_ACK_ENTRY;
                o_res.entry_addr = r_rd_data;
                o_res.last       = w_entry_last;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_idx      = r_idx + CNT_W'(1);
                end else begin
                    n_idx = r_idx;
                end
            end
            default: ;
        endcase

        o_res.list_overflow   = n_ovf;
        o_res.delivered_total = n_deliv;
        o_res.error_total     = n_err;
        o_res.sent_total      = n_sent;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_running   <= 1'b0;
            r_in_rx     <= 1'b0;
            r_radio     <= RADIO_IDLE;
            r_countdown <= 32'd0;
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_deliv     <= 32'd0;
            r_err       <= 32'd0;
            r_sent      <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_in_rx     <= n_in_rx;
            r_radio     <= n_radio;
            r_countdown <= n_countdown;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_ovf       <= n_ovf;
            r_deliv     <= n_deliv;
            r_err       <= n_err;
            r_sent      <= n_sent;
        end
    end

    // success list memory, read one index ahead of the walk
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_job.src_addr;
        end
        r_rd_data <= r_mem[n_idx[IDX_W-1:0]];
    end

endmodule

// ===== rtl/core/slotted_mac_sink_ack_collector.sv =====
// ----------------------------------------------------------------------------
// slotted_mac_sink_ack_collector
// Sink side of a framed slotted-ALOHA MAC that collects acknowledgments.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on push/full as one t_item (tick, start, stop, receive
//   start, receive end, transmit end). Results leave on empty/pop as one
//   t_result each, oldest first; the final result of a request has last set.
//   Registers are written over the APB-style port at byte address 4*index;
//   the user must write them only while no request is in flight (unchecked).
// Flow and throughput:
//   A request is registered in the job queue, and its results in the result
//   queue. A two-entry job queue separates decode from execution, so the block
//   takes one request per cycle until it fills. Execution handles one job per
//   cycle while the result queue has room and no list walk runs; the tick
//   that closes a receive window starts the list walk, which reads one listed
//   address per cycle from the success list memory while the queue has room.
// Reset:
//   Synchronous, active low; clears control state, counters and registers
//   to their defaults. The list contents are not cleared, only its count.
// Stalls:
//   While pop stays low the two-entry result queue fills, execution halts,
//   then the job queue fills and full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module slotted_mac_sink_ack_collector #(
    parameter int MAX_NODES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  smac_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output smac_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import smac_pkg::*;

    t_cfg    r_cfg;
    logic    w_cfg_wr;
    logic    w_q_full;
    logic    w_q_push;
    t_job    w_job_in;
    t_job    w_job_out;
    logic    w_job_empty;
    logic    w_job_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_addr    <= RST_OWN_ADDR;
            r_cfg.rx_window   <= RST_RX_WINDOW;
            r_cfg.tx_period   <= RST_TX_PERIOD;
            r_cfg.start_delay <= RST_START_DELAY;
            r_cfg.entry_bytes <= RST_ENTRY_BYTES;
            r_cfg.node_count  <= RST_NODE_COUNT;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_OWN_ADDR:    r_cfg.own_addr    <= pwdata[7:0];
                REG_RX_WINDOW:   r_cfg.rx_window   <= pwdata;
                REG_TX_PERIOD:   r_cfg.tx_period   <= pwdata;
                REG_START_DELAY: r_cfg.start_delay <= pwdata;
                REG_ENTRY_BYTES: r_cfg.entry_bytes <= pwdata[7:0];
                REG_NODE_COUNT:  r_cfg.node_count  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // configuration register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_OWN_ADDR:    prdata = {24'd0, r_cfg.own_addr};
            REG_RX_WINDOW:   prdata = r_cfg.rx_window;
            REG_TX_PERIOD:   prdata = r_cfg.tx_period;
            REG_START_DELAY: prdata = r_cfg.start_delay;
            REG_ENTRY_BYTES: prdata = {24'd0, r_cfg.entry_bytes};
            REG_NODE_COUNT:  prdata = {26'd0, r_cfg.node_count};
            default:         prdata = 32'd0;
        endcase
    end

    // request decode
    smac_front u_front (
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .i_own_addr (r_cfg.own_addr),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_job      (w_job_in)
    );

    // job queue between decode and execution
    smac_queue #(
        .T (t_job)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_job_in),
        .o_full  (w_q_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    // execution
    smac_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (!w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // result queue
    smac_queue #(
        .T (t_result)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // header fields appear only on the header result
    a_header_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.kind != KIND_ACK_HEADER |->
            o_result.ack_bytes == 14'd0 && o_result.ack_count == 6'd0)
        else $error("header fields on a non-header result");

    // entry address appears only on entry results
    a_entry_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.kind != KIND_ACK_ENTRY |-> o_result.entry_addr == 8'd0)
        else $error("entry address on a non-entry result");

    // a waiting result is kept until it is taken
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result lost");

endmodule
